@@ rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, character codes and types of the sensor frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // default configuration
    localparam int TIME_FIELD_LIMIT_DEF = 999;
    localparam int QUEUE_DEPTH_DEF      = 2;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int HOURS_W    = 10;
    localparam int MINUTES_W  = 10;
    localparam int SECONDS_W  = 7;
    localparam int REMAIN_W   = 23;
    localparam int SETPOINT_W = 18;
    localparam int FLAGS_W    = 3;

    localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = 18'd3600;

    // time arithmetic
    localparam int SECONDS_LIMIT = 99;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_MIN   = 60;
    localparam int SECONDS_CHARS = 2;

    // ascii codes
    localparam logic [BYTE_W-1:0] CH_FRAME_START = 8'h23; // '#'
    localparam logic [BYTE_W-1:0] CH_FRAME_END   = 8'h24; // '$'
    localparam logic [BYTE_W-1:0] CH_TEMP        = 8'h54; // 'T'
    localparam logic [BYTE_W-1:0] CH_HUM         = 8'h48; // 'H'
    localparam logic [BYTE_W-1:0] CH_STATUS      = 8'h53; // 'S'
    localparam logic [BYTE_W-1:0] CH_TIME        = 8'h72; // 'r'
    localparam logic [BYTE_W-1:0] CH_HOUR        = 8'h68; // 'h'
    localparam logic [BYTE_W-1:0] CH_MIN         = 8'h6D; // 'm'
    localparam logic [BYTE_W-1:0] CH_SEC         = 8'h73; // 's'
    localparam logic [BYTE_W-1:0] CH_LIGHT       = 8'h49; // 'I'
    localparam logic [BYTE_W-1:0] CH_IRRIG       = 8'h52; // 'R'
    localparam logic [BYTE_W-1:0] CH_VENT        = 8'h56; // 'V'
    localparam logic [BYTE_W-1:0] CH_ZERO        = 8'h30; // '0'
    localparam logic [BYTE_W-1:0] CH_ONE         = 8'h31; // '1'
    localparam logic [BYTE_W-1:0] CH_NINE        = 8'h39; // '9'

    // reading kinds
    localparam logic [KIND_W-1:0] READ_NONE = 2'd0;
    localparam logic [KIND_W-1:0] READ_TEMP = 2'd1;
    localparam logic [KIND_W-1:0] READ_HUM  = 2'd2;

    // event kinds
    localparam logic EVT_STATUS = 1'b0;
    localparam logic EVT_FRAME  = 1'b1;

    // status flag bit positions
    localparam int FLAG_LIGHT = 0;
    localparam int FLAG_IRRIG = 1;
    localparam int FLAG_VENT  = 2;

    // fixed-width part of one queued item; hours and minutes travel beside it
    typedef struct packed {
        logic                  event_kind;
        logic [KIND_W-1:0]     reading_kind;
        logic [BYTE_W-1:0]     reading_high_char;
        logic [BYTE_W-1:0]     reading_low_char;
        logic [SECONDS_W-1:0]  seconds;
        logic [FLAGS_W-1:0]    flags;
    } item_fixed_t;

endpackage

@@ rtl/sfr_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_in_if
// Input channel: one received serial byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfr_in_if
    import sfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sfr_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_out_if
// Result channel: status and frame-completion items, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfr_out_if
    import sfr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       event_kind;
    logic [KIND_W-1:0]          reading_kind;
    logic [BYTE_W-1:0]          reading_high_char;
    logic [BYTE_W-1:0]          reading_low_char;
    logic [HOURS_W-1:0]         hours;
    logic [MINUTES_W-1:0]       minutes;
    logic [SECONDS_W-1:0]       seconds;
    logic                       remaining_valid;
    logic signed [REMAIN_W-1:0] remaining_seconds;
    logic                       light_on;
    logic                       irrigation_on;
    logic                       vent_on;

    modport source (
        output valid, output event_kind, output reading_kind,
        output reading_high_char, output reading_low_char,
        output hours, output minutes, output seconds,
        output remaining_valid, output remaining_seconds,
        output light_on, output irrigation_on, output vent_on,
        input  ready
    );
    modport sink (
        input  valid, input event_kind, input reading_kind,
        input  reading_high_char, input reading_low_char,
        input  hours, input minutes, input seconds,
        input  remaining_valid, input remaining_seconds,
        input  light_on, input irrigation_on, input vent_on,
        output ready
    );
endinterface

@@ rtl/sfr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_front
// Byte parser: frame state machine, reading and status registers, time field
// accumulators; pushes one queue item per status update or closed frame.
// ----------------------------------------------------------------------------
module sfr_front
    import sfr_pkg::*;
#(
    parameter  int TIME_FIELD_LIMIT = TIME_FIELD_LIMIT_DEF,
    localparam int TW               = $clog2(TIME_FIELD_LIMIT + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    sfr_in_if.sink        rx,
    input  logic          q_full,
    output logic          push_valid,
    output logic [TW-1:0] push_hours,
    output logic [TW-1:0] push_minutes,
    output item_fixed_t   push_fixed
);

    // parser states
    localparam logic [3:0] ST_WAIT    = 4'd0;
    localparam logic [3:0] ST_PARAM   = 4'd1;
    localparam logic [3:0] ST_STATUS  = 4'd2;
    localparam logic [3:0] ST_TIME    = 4'd3;
    localparam logic [3:0] ST_HOURS   = 4'd4;
    localparam logic [3:0] ST_MINUTES = 4'd5;
    localparam logic [3:0] ST_SECONDS = 4'd6;
    localparam logic [3:0] ST_LIGHT   = 4'd7;
    localparam logic [3:0] ST_IRRIG   = 4'd8;
    localparam logic [3:0] ST_VENT    = 4'd9;
    localparam logic [3:0] ST_T_HI    = 4'd10;
    localparam logic [3:0] ST_T_LO    = 4'd11;
    localparam logic [3:0] ST_H_HI    = 4'd12;
    localparam logic [3:0] ST_H_LO    = 4'd13;
    localparam logic [3:0] ST_END     = 4'd14;

    localparam int MW = TW + 4;
    localparam int SW = SECONDS_W + 4;

    logic [3:0]           state_reg, state_next;
    logic [KIND_W-1:0]    select_reg, select_next;
    logic [BYTE_W-1:0]    first_reg, first_next;
    logic [BYTE_W-1:0]    second_reg, second_next;
    logic [TW-1:0]        hours_reg, hours_next;
    logic                 hours_bad_reg, hours_bad_next;
    logic [TW-1:0]        minutes_reg, minutes_next;
    logic                 minutes_bad_reg, minutes_bad_next;
    logic [SECONDS_W-1:0] seconds_reg, seconds_next;
    logic                 seconds_bad_reg, seconds_bad_next;
    logic [1:0]           sec_count_reg, sec_count_next;
    logic [FLAGS_W-1:0]   flags_reg, flags_next;

    logic                 accept;
    logic [BYTE_W-1:0]    b;
    logic                 digit_ok;
    logic [3:0]           digit;
    logic [MW-1:0]        hours_mac, minutes_mac;
    logic [SW-1:0]        seconds_mac;
    logic [TW-1:0]        hours_sat, minutes_sat;
    logic [SECONDS_W-1:0] seconds_sat;
    logic                 emit_status, emit_frame;
    logic [1:0]           flag_idx;

    assign accept   = rx.valid && rx.ready;
    assign rx.ready = !q_full;
    assign b        = rx.rx_byte;

    // digit decode and saturating decimal accumulate
    assign digit_ok = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit    = 4'(b - CH_ZERO);

    assign hours_mac   = (MW'(hours_reg) << 3) + (MW'(hours_reg) << 1) + MW'(digit);
    assign minutes_mac = (MW'(minutes_reg) << 3) + (MW'(minutes_reg) << 1) + MW'(digit);
    assign seconds_mac = (SW'(seconds_reg) << 3) + (SW'(seconds_reg) << 1) + SW'(digit);

    assign hours_sat   = (hours_mac > MW'(TIME_FIELD_LIMIT)) ?
                         TW'(TIME_FIELD_LIMIT) : hours_mac[TW-1:0];
    assign minutes_sat = (minutes_mac > MW'(TIME_FIELD_LIMIT)) ?
                         TW'(TIME_FIELD_LIMIT) : minutes_mac[TW-1:0];
    assign seconds_sat = (seconds_mac > SW'(SECONDS_LIMIT)) ?
                         SECONDS_W'(SECONDS_LIMIT) : seconds_mac[SECONDS_W-1:0];

    // parser next state
    always_comb
    begin
        state_next       = state_reg;
        select_next      = select_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        hours_next       = hours_reg;
        hours_bad_next   = hours_bad_reg;
        minutes_next     = minutes_reg;
        minutes_bad_next = minutes_bad_reg;
        seconds_next     = seconds_reg;
        seconds_bad_next = seconds_bad_reg;
        sec_count_next   = sec_count_reg;
        flags_next       = flags_reg;
        emit_status      = 1'b0;
        emit_frame       = 1'b0;
        flag_idx         = 2'(FLAG_LIGHT);

        if (accept)
        begin
            case (state_reg)
                ST_WAIT:
                begin
                    if (b == CH_FRAME_START)
                    begin
                        state_next = ST_PARAM;
                    end
                end
                ST_PARAM:
                begin
                    if (b == CH_TEMP)
                    begin
                        state_next  = ST_T_HI;
                        select_next = READ_TEMP;
                    end
                    else if (b == CH_HUM)
                    begin
                        state_next  = ST_H_HI;
                        select_next = READ_HUM;
                    end
                    else if (b == CH_STATUS)
                    begin
                        state_next = ST_STATUS;
                    end
                    else if (b == CH_TIME)
                    begin
                        state_next = ST_TIME;
                    end
                    else
                    begin
                        state_next = ST_END;
                    end
                end
                ST_STATUS:
                begin
                    // unknown letters are skipped while waiting for one
                    if (b == CH_LIGHT)
                    begin
                        state_next = ST_LIGHT;
                    end
                    else if (b == CH_IRRIG)
                    begin
                        state_next = ST_IRRIG;
                    end
                    else if (b == CH_VENT)
                    begin
                        state_next = ST_VENT;
                    end
                end
                ST_TIME:
                begin
                    if (b == CH_HOUR)
                    begin
                        state_next = ST_HOURS;
                    end
                    else if (b == CH_MIN)
                    begin
                        state_next = ST_MINUTES;
                    end
                    else if (b == CH_SEC)
                    begin
                        state_next = ST_SECONDS;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
                ST_HOURS:
                begin
                    if (b == CH_MIN)
                    begin
                        state_next = ST_MINUTES;
                    end
                    else if (digit_ok)
                    begin
                        hours_next = hours_sat;
                    end
                    else
                    begin
                        hours_bad_next = 1'b1;
                    end
                end
                ST_MINUTES:
                begin
                    if (b == CH_SEC)
                    begin
                        state_next = ST_SECONDS;
                    end
                    else if (digit_ok)
                    begin
                        minutes_next = minutes_sat;
                    end
                    else
                    begin
                        minutes_bad_next = 1'b1;
                    end
                end
                ST_SECONDS:
                begin
                    if (digit_ok)
                    begin
                        seconds_next = seconds_sat;
                    end
                    else
                    begin
                        seconds_bad_next = 1'b1;
                    end
                    sec_count_next = sec_count_reg + 2'd1;
                    if (sec_count_next >= 2'(SECONDS_CHARS))
                    begin
                        state_next = ST_END;
                    end
                end
                ST_LIGHT, ST_IRRIG, ST_VENT:
                begin
                    if (state_reg == ST_IRRIG)
                    begin
                        flag_idx = 2'(FLAG_IRRIG);
                    end
                    else if (state_reg == ST_VENT)
                    begin
                        flag_idx = 2'(FLAG_VENT);
                    end
                    state_next = ST_END;
                    if (b == CH_ONE)
                    begin
                        flags_next[flag_idx] = 1'b1;
                        emit_status          = 1'b1;
                    end
                    else if (b == CH_ZERO)
                    begin
                        flags_next[flag_idx] = 1'b0;
                        emit_status          = 1'b1;
                    end
                end
                ST_T_HI:
                begin
                    first_next = b;
                    state_next = ST_T_LO;
                end
                ST_H_HI:
                begin
                    first_next = b;
                    state_next = ST_H_LO;
                end
                ST_T_LO, ST_H_LO:
                begin
                    second_next = b;
                    state_next  = ST_END;
                end
                ST_END:
                begin
                    // only the closing byte reports and clears the time fields
                    if (b == CH_FRAME_END)
                    begin
                        emit_frame       = 1'b1;
                        hours_next       = '0;
                        hours_bad_next   = 1'b0;
                        minutes_next     = '0;
                        minutes_bad_next = 1'b0;
                        seconds_next     = '0;
                        seconds_bad_next = 1'b0;
                    end
                    sec_count_next = 2'd0;
                    state_next     = ST_WAIT;
                end
                default:
                begin
                    state_next = ST_WAIT;
                end
            endcase
        end
    end

    // queue item build
    always_comb
    begin
        push_valid                   = emit_status || emit_frame;
        push_fixed.event_kind        = emit_frame ? EVT_FRAME : EVT_STATUS;
        push_fixed.reading_kind      = select_reg;
        push_fixed.reading_high_char = first_reg;
        push_fixed.reading_low_char  = second_reg;
        push_fixed.flags             = flags_next;
        push_hours                   = '0;
        push_minutes                 = '0;
        push_fixed.seconds           = '0;
        if (emit_frame)
        begin
            push_hours         = hours_bad_reg ? '0 : hours_reg;
            push_minutes       = minutes_bad_reg ? '0 : minutes_reg;
            push_fixed.seconds = seconds_bad_reg ? '0 : seconds_reg;
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_WAIT;
            select_reg      <= READ_NONE;
            first_reg       <= CH_ZERO;
            second_reg      <= CH_ZERO;
            hours_reg       <= '0;
            hours_bad_reg   <= 1'b0;
            minutes_reg     <= '0;
            minutes_bad_reg <= 1'b0;
            seconds_reg     <= '0;
            seconds_bad_reg <= 1'b0;
            sec_count_reg   <= 2'd0;
            flags_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            select_reg      <= select_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            hours_reg       <= hours_next;
            hours_bad_reg   <= hours_bad_next;
            minutes_reg     <= minutes_next;
            minutes_bad_reg <= minutes_bad_next;
            seconds_reg     <= seconds_next;
            seconds_bad_reg <= seconds_bad_next;
            sec_count_reg   <= sec_count_next;
            flags_reg       <= flags_next;
        end
    end

endmodule

@@ rtl/sfr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_queue
// Small register queue that decouples the parser from the result pipeline.
// ----------------------------------------------------------------------------
module sfr_queue
    import sfr_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] q_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];
    assign do_push = push_valid && !full;
    assign do_pop  = pop && q_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/sfr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_back
// Result pipeline: scales the time fields to seconds, then forms the
// remaining irrigation time in the output register.
// ----------------------------------------------------------------------------
module sfr_back
    import sfr_pkg::*;
#(
    parameter  int TIME_FIELD_LIMIT = TIME_FIELD_LIMIT_DEF,
    localparam int TW               = $clog2(TIME_FIELD_LIMIT + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  logic [TW-1:0]         q_hours,
    input  logic [TW-1:0]         q_minutes,
    input  item_fixed_t           q_fixed,
    output logic                  q_pop,
    input  logic [SETPOINT_W-1:0] setpoint,
    sfr_out_if.source             res
);

    localparam int RW = REMAIN_W;
    localparam int PW = (TW + 12 > RW) ? TW + 12 : RW;

    // scale stage
    logic                 a_valid_reg;
    item_fixed_t          a_fixed_reg;
    logic [HOURS_W-1:0]   a_hours_reg;
    logic [MINUTES_W-1:0] a_minutes_reg;
    logic [RW-1:0]        a_hprod_reg;
    logic [RW-1:0]        a_mprod_reg;
    logic                 a_nz_reg;
    logic                 a_ready;
    logic [PW-1:0]        hprod, mprod;

    // output stage
    logic                 out_valid_reg;
    logic                 out_ready;
    item_fixed_t          out_fixed_reg;
    logic [HOURS_W-1:0]   hours_reg;
    logic [MINUTES_W-1:0] minutes_reg;
    logic                 rem_valid_reg;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        total;
    logic [RW-1:0]        rem_next;

    assign out_ready = !out_valid_reg || res.ready;
    assign a_ready   = !a_valid_reg || out_ready;
    assign q_pop     = q_valid && a_ready;

    // only the low result bits of the total matter for the wrapped difference
    assign hprod = PW'(q_hours) * PW'(SEC_PER_HOUR);
    assign mprod = PW'(q_minutes) * PW'(SEC_PER_MIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_fixed_reg   <= q_fixed;
            a_hours_reg   <= HOURS_W'(q_hours);
            a_minutes_reg <= MINUTES_W'(q_minutes);
            a_hprod_reg   <= hprod[RW-1:0];
            a_mprod_reg   <= mprod[RW-1:0];
            a_nz_reg      <= (q_hours != '0) || (q_minutes != '0) || (q_fixed.seconds != '0);
        end
    end

    // total and remaining time
    assign total    = a_hprod_reg + a_mprod_reg + RW'(a_fixed_reg.seconds);
    assign rem_next = a_nz_reg ? (RW'(setpoint) - total) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && a_valid_reg)
        begin
            out_fixed_reg <= a_fixed_reg;
            hours_reg     <= a_hours_reg;
            minutes_reg   <= a_minutes_reg;
            rem_valid_reg <= a_nz_reg;
            rem_reg       <= rem_next;
        end
    end

    // result channel
    assign res.valid             = out_valid_reg;
    assign res.event_kind        = out_fixed_reg.event_kind;
    assign res.reading_kind      = out_fixed_reg.reading_kind;
    assign res.reading_high_char = out_fixed_reg.reading_high_char;
    assign res.reading_low_char  = out_fixed_reg.reading_low_char;
    assign res.hours             = hours_reg;
    assign res.minutes           = minutes_reg;
    assign res.seconds           = out_fixed_reg.seconds;
    assign res.remaining_valid   = rem_valid_reg;
    assign res.remaining_seconds = $signed(rem_reg);
    assign res.light_on          = out_fixed_reg.flags[FLAG_LIGHT];
    assign res.irrigation_on     = out_fixed_reg.flags[FLAG_IRRIG];
    assign res.vent_on           = out_fixed_reg.flags[FLAG_VENT];

endmodule

@@ rtl/sensor_frame_receiver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_receiver_core
// Serial sensor/status frame parser with irrigation time reporting.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle on rx and parses frames
// of the form '#' letter ... '$'. A status byte after SI, SR or SV gives a
// status item; the closing '$' gives a frame item with the kept reading, the
// decoded time and the remaining irrigation seconds. Bytes are taken every
// cycle while the two-entry queue behind the parser has room; a result
// reaches res through the parser and queue write, the scale stage and the
// output register. The setpoint register is written through
// cfg_wr_en/cfg_wr_data and resets to 3600 seconds.
// ----------------------------------------------------------------------------
module sensor_frame_receiver_core
    import sfr_pkg::*;
#(
    parameter int TIME_FIELD_LIMIT = TIME_FIELD_LIMIT_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sfr_in_if.sink                rx,
    sfr_out_if.source             res,
    input  logic                  cfg_wr_en,
    input  logic [SETPOINT_W-1:0] cfg_wr_data
);

    localparam int TW = $clog2(TIME_FIELD_LIMIT + 1);
    localparam int QW = 2 * TW + $bits(item_fixed_t);

    logic [SETPOINT_W-1:0] setpoint_reg;
    logic                  push_valid;
    logic [TW-1:0]         push_hours, push_minutes;
    item_fixed_t           push_fixed;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    logic [QW-1:0]         q_data;

    // setpoint register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= SETPOINT_RESET;
        end
        else if (cfg_wr_en)
        begin
            setpoint_reg <= cfg_wr_data;
        end
    end

    // parser
    sfr_front #(
        .TIME_FIELD_LIMIT (TIME_FIELD_LIMIT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx),
        .q_full       (q_full),
        .push_valid   (push_valid),
        .push_hours   (push_hours),
        .push_minutes (push_minutes),
        .push_fixed   (push_fixed)
    );

    // decoupling queue
    sfr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  ({push_hours, push_minutes, push_fixed}),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_data     (q_data)
    );

    // result pipeline
    sfr_back #(
        .TIME_FIELD_LIMIT (TIME_FIELD_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_hours   (q_data[QW-1 -: TW]),
        .q_minutes (q_data[QW-TW-1 -: TW]),
        .q_fixed   (item_fixed_t'(q_data[$bits(item_fixed_t)-1:0])),
        .q_pop     (q_pop),
        .setpoint  (setpoint_reg),
        .res       (res)
    );

endmodule

@@ rtl/sfr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module sfr_checker
    import sfr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       event_kind,
    input  logic [KIND_W-1:0]          reading_kind,
    input  logic [BYTE_W-1:0]          reading_high_char,
    input  logic [BYTE_W-1:0]          reading_low_char,
    input  logic [HOURS_W-1:0]         hours,
    input  logic [MINUTES_W-1:0]       minutes,
    input  logic [SECONDS_W-1:0]       seconds,
    input  logic                       remaining_valid,
    input  logic signed [REMAIN_W-1:0] remaining_seconds
);

    // a stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(hours) && $stable(minutes) && $stable(seconds)
            && $stable(remaining_seconds))
    else $error("stalled result item changed");

    // status items carry no time
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EVT_STATUS |->
            hours == '0 && minutes == '0 && seconds == '0 && !remaining_valid)
    else $error("status item with time fields");

    // remaining time only with a nonzero total
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !remaining_valid |-> remaining_seconds == '0)
    else $error("remaining seconds without a valid total");

    // no reading yet means the reset characters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reading_kind == READ_NONE |->
            reading_high_char == CH_ZERO && reading_low_char == CH_ZERO)
    else $error("reading characters without a reading");

    // a valid remaining time comes only with a closed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && remaining_valid |-> event_kind == EVT_FRAME)
    else $error("remaining time on a status item");

endmodule

bind sensor_frame_receiver_core sfr_checker u_sfr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (res.valid),
    .out_ready         (res.ready),
    .event_kind        (res.event_kind),
    .reading_kind      (res.reading_kind),
    .reading_high_char (res.reading_high_char),
    .reading_low_char  (res.reading_low_char),
    .hours             (res.hours),
    .minutes           (res.minutes),
    .seconds           (res.seconds),
    .remaining_valid   (res.remaining_valid),
    .remaining_seconds (res.remaining_seconds)
);
